// ===== rtl/core/pulse_width_to_pwm_words_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse width to PWM words core
// Concurrent assertions that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_TO_PWM_WORDS_CORE_DEFINES_SVH
`define PULSE_WIDTH_TO_PWM_WORDS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PWMW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pwmw assertion failed");
`define PWMW_ASSERT_NEVER(name, clk, rst_n, prop) \
  `PWMW_ASSERT(name, clk, rst_n, not (prop))
`else
`define PWMW_ASSERT(name, clk, rst_n, prop)
`define PWMW_ASSERT_NEVER(name, clk, rst_n, prop)
`endif
`endif

// ===== rtl/core/pwmw_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse width to PWM words package
// Widths, base period tables and the entry type shared by the core modules.
// ----------------------------------------------------------------------------
package pwmw_pkg;

  localparam int unsigned NsWidth      = 18;
  localparam int unsigned BitsWidth    = 8;
  localparam int unsigned DivWidth     = 9;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned WordIdxWidth = 5;
  localparam int unsigned NumBases     = 11;
  localparam int unsigned IdxWidth     = 4;
  localparam int unsigned NumStages    = NumBases + 1;

  localparam int unsigned PulseMinNs = 4;
  localparam int unsigned PulseMaxNs = 224000;

  // Reciprocals are exact quotients for every dividend below 2**18.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipWidth = 27;
  localparam int unsigned ProdWidth  = NsWidth + RecipWidth;
  localparam int unsigned QuotWidth  = 16;
  localparam int unsigned RecipOne   = 1 << RecipShift;

  localparam int unsigned BasePeriod [NumBases] = '{
    4, 8, 10, 20, 40, 80, 100, 200, 250, 500, 1000
  };

  localparam int unsigned Recip [NumBases] = '{
    (RecipOne + 4 - 1) / 4,     (RecipOne + 8 - 1) / 8,
    (RecipOne + 10 - 1) / 10,   (RecipOne + 20 - 1) / 20,
    (RecipOne + 40 - 1) / 40,   (RecipOne + 80 - 1) / 80,
    (RecipOne + 100 - 1) / 100, (RecipOne + 200 - 1) / 200,
    (RecipOne + 250 - 1) / 250, (RecipOne + 500 - 1) / 500,
    (RecipOne + 1000 - 1) / 1000
  };

  localparam int unsigned HalfPeriod [NumBases] = '{
    4 / 2, 8 / 2, 10 / 2, 20 / 2, 40 / 2, 80 / 2,
    100 / 2, 200 / 2, 250 / 2, 500 / 2, 1000 / 2
  };

  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = 2;
  localparam int unsigned QueueCntWidth = 3;

  typedef struct packed {
    logic [DivWidth-1:0]  divider;
    logic [BitsWidth-1:0] bits;
  } pwmw_entry_t;

endpackage

// ===== rtl/core/pwmw_search.sv =====
// ----------------------------------------------------------------------------
// Base period search pipeline
// Clamps the request and tries one base period per stage, keeping the best.
// ----------------------------------------------------------------------------
module pwmw_search #(
  parameter int unsigned MaxPulseBits = 224
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [pwmw_pkg::NsWidth-1:0]     pulse_ns_i,
  output logic                             full_o,
  output logic                             entry_valid_o,
  output pwmw_pkg::pwmw_entry_t            entry_o,
  input  logic                             entry_full_i
);
  import pwmw_pkg::*;

  localparam int unsigned Last = NumStages - 1;

  logic                  valid_q [NumStages];
  logic [NsWidth-1:0]    ns_q    [NumStages];
  logic [NsWidth-1:0]    err_q   [NumStages];
  logic [IdxWidth-1:0]   idx_q   [NumStages];
  logic [BitsWidth-1:0]  bits_q  [NumStages];
  logic [ProdWidth-1:0]  prod_q  [NumBases];

  logic               adv;
  logic [NsWidth-1:0] ns_clamped;

  assign adv    = !(valid_q[Last] && entry_full_i);
  assign full_o = !adv;

  always_comb begin
    priority if (pulse_ns_i < NsWidth'(PulseMinNs)) begin
      ns_clamped = NsWidth'(PulseMinNs);
    end else if (pulse_ns_i > NsWidth'(PulseMaxNs)) begin
      ns_clamped = NsWidth'(PulseMaxNs);
    end else begin
      ns_clamped = pulse_ns_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ns_q[0]   <= ns_clamped;
      err_q[0]  <= '1;
      idx_q[0]  <= '0;
      bits_q[0] <= '0;
      prod_q[0] <= ProdWidth'(ns_clamped) * ProdWidth'(Recip[0]);
    end
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    logic [QuotWidth-1:0] quot;
    logic [BitsWidth-1:0] cnt;
    logic [NsWidth-1:0]   err;
    logic                 take;

    always_comb begin
      quot = prod_q[k-1][RecipShift +: QuotWidth];
      cnt  = (quot > QuotWidth'(MaxPulseBits)) ? BitsWidth'(MaxPulseBits)
                                                : quot[BitsWidth-1:0];
      err  = ns_q[k-1] - NsWidth'(cnt) * NsWidth'(BasePeriod[k-1]);
      take = err < err_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ns_q[k]   <= ns_q[k-1];
        err_q[k]  <= take ? err : err_q[k-1];
        idx_q[k]  <= take ? IdxWidth'(k - 1) : idx_q[k-1];
        bits_q[k] <= take ? cnt : bits_q[k-1];
      end
    end

    if (k < NumBases) begin : g_mul
      always_ff @(posedge clk_i) begin
        if (adv) begin
          prod_q[k] <= ProdWidth'(ns_q[k-1]) * ProdWidth'(Recip[k]);
        end
      end
    end
  end

  assign entry_valid_o   = valid_q[Last];
  assign entry_o.divider = DivWidth'(HalfPeriod[idx_q[Last]]);
  assign entry_o.bits    = (bits_q[Last] == '0) ? BitsWidth'(1) : bits_q[Last];

endmodule

// ===== rtl/core/pwmw_queue.sv =====
// ----------------------------------------------------------------------------
// Entry queue
// Small queue that decouples the search pipeline from the word emitter.
// ----------------------------------------------------------------------------
module pwmw_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pwmw_pkg::pwmw_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output pwmw_pkg::pwmw_entry_t entry_o
);
  import pwmw_pkg::*;

  pwmw_entry_t              slot_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntWidth-1:0] cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntWidth'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrWidth'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueuePtrWidth'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QueueCntWidth'(do_push) - QueueCntWidth'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/pwmw_emit.sv =====
// ----------------------------------------------------------------------------
// Word emitter
// Expands one queue entry into its serializer words, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "pulse_width_to_pwm_words_core_defines.svh"

module pwmw_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  pwmw_pkg::pwmw_entry_t           q_entry_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [pwmw_pkg::WordBits-1:0]   fifo_word_o,
  output logic [pwmw_pkg::DivWidth-1:0]   clock_divider_o,
  output logic [pwmw_pkg::BitsWidth-1:0]  pulse_bits_o,
  output logic                            last_o
);
  import pwmw_pkg::*;

  logic                 act_q, act_d;
  logic [BitsWidth-1:0] rem_q, rem_d;
  logic [DivWidth-1:0]  act_div_q;
  logic [BitsWidth-1:0] act_bits_q;

  logic                 out_v_q, out_v_d;
  logic [WordBits-1:0]  word_q;
  logic [DivWidth-1:0]  div_q;
  logic [BitsWidth-1:0] bits_q;
  logic                 last_q;

  logic                 load_ok, emit, is_last, fetch;
  logic [WordBits-1:0]  word_d;
  logic [BitsWidth-1:0] rem_next;

  assign load_ok = !out_v_q || pop_i;
  assign emit    = act_q && load_ok;
  assign is_last = (rem_q == '0);
  assign fetch   = !q_empty_i && (!act_q || (emit && is_last));
  assign q_pop_o = fetch;

  always_comb begin
    priority if (rem_q >= BitsWidth'(WordBits)) begin
      word_d   = '1;
      rem_next = rem_q - BitsWidth'(WordBits);
    end else if (rem_q != '0) begin
      word_d   = ~({WordBits{1'b1}} >> rem_q[WordIdxWidth-1:0]);
      rem_next = '0;
    end else begin
      word_d   = '0;
      rem_next = '0;
    end
  end

  always_comb begin
    act_d = act_q;
    rem_d = rem_q;
    if (fetch) begin
      act_d = 1'b1;
      rem_d = q_entry_i.bits;
    end else if (emit) begin
      act_d = !is_last;
      rem_d = rem_next;
    end
    out_v_d = emit ? 1'b1 : (out_v_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (fetch) begin
      act_div_q  <= q_entry_i.divider;
      act_bits_q <= q_entry_i.bits;
    end
    if (emit) begin
      word_q <= word_d;
      div_q  <= act_div_q;
      bits_q <= act_bits_q;
      last_q <= is_last;
    end
  end

  assign empty_o         = !out_v_q;
  assign fifo_word_o     = word_q;
  assign clock_divider_o = div_q;
  assign pulse_bits_o    = bits_q;
  assign last_o          = last_q;

  `PWMW_ASSERT(a_last_word_zero, clk_i, rst_ni, out_v_q && last_q |-> word_q == '0)
  `PWMW_ASSERT(a_pulse_word_msb, clk_i, rst_ni, out_v_q && !last_q |-> word_q[WordBits-1])
  `PWMW_ASSERT(a_rem_bounded, clk_i, rst_ni, act_q |-> rem_q <= act_bits_q)
  `PWMW_ASSERT_NEVER(a_fetch_busy, clk_i, rst_ni, act_q && !(emit && is_last) && fetch)

endmodule

// ===== rtl/core/pulse_width_to_pwm_words_core.sv =====
// ----------------------------------------------------------------------------
// Pulse width to PWM words core
// Turns a pulse length in ns into serializer words with divider and bit count.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// request   in         push_i / full_o  pulse_ns_i
// word      out        pop_i / empty_o  fifo_word_o, clock_divider_o,
//                                       pulse_bits_o, last_o
//
// A request yields 2 to 8 words, set by the word emitter.
// The base period search is a 12-stage pipeline: an input stage, then one base period per stage.
// Reset clears only control state; no clearing pass is needed.
// The search stalls only when its last stage holds an entry and the queue is full.
// ----------------------------------------------------------------------------
module pulse_width_to_pwm_words_core #(
  parameter int unsigned MaxPulseBits = 224
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [pwmw_pkg::NsWidth-1:0]    pulse_ns_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [pwmw_pkg::WordBits-1:0]   fifo_word_o,
  output logic [pwmw_pkg::DivWidth-1:0]   clock_divider_o,
  output logic [pwmw_pkg::BitsWidth-1:0]  pulse_bits_o,
  output logic                            last_o
);
  import pwmw_pkg::*;

  logic        srch_valid;
  pwmw_entry_t srch_entry;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  pwmw_entry_t q_entry;

  pwmw_search #(
    .MaxPulseBits(MaxPulseBits)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .pulse_ns_i   (pulse_ns_i),
    .full_o       (full_o),
    .entry_valid_o(srch_valid),
    .entry_o      (srch_entry),
    .entry_full_i (q_full)
  );

  pwmw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (srch_valid),
    .entry_i(srch_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .entry_o(q_entry)
  );

  pwmw_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .fifo_word_o    (fifo_word_o),
    .clock_divider_o(clock_divider_o),
    .pulse_bits_o   (pulse_bits_o),
    .last_o         (last_o)
  );

endmodule

// ===== dv/pwm_words_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM word checker
// Watches the request and word channels of the core. For each accepted
// request it works out the serializer words, divider and bit count, and
// compares every popped word with the oldest word still due.
// ----------------------------------------------------------------------------
module pwm_words_check #(
  parameter int unsigned MaxBits = 224
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_o,
  input  logic [pwmw_pkg::NsWidth-1:0]    pulse_ns_i,
  input  logic                            empty_o,
  input  logic                            pop_i,
  input  logic [pwmw_pkg::WordBits-1:0]   fifo_word_o,
  input  logic [pwmw_pkg::DivWidth-1:0]   clock_divider_o,
  input  logic [pwmw_pkg::BitsWidth-1:0]  pulse_bits_o,
  input  logic                            last_o,
  output int                              fail_count_o,
  output int                              words_due_o
);

  localparam int unsigned NumPeriods = 11;
  localparam int unsigned PeriodNs [NumPeriods] = '{
    4, 8, 10, 20, 40, 80, 100, 200, 250, 500, 1000
  };
  localparam int unsigned ShortestNs = 4;
  localparam int unsigned LongestNs  = 224000;
  localparam int unsigned BitsPerWord = 32;
  localparam int unsigned MaxDataWords = 7;

  typedef struct {
    logic [pwmw_pkg::WordBits-1:0]  word;
    logic [pwmw_pkg::DivWidth-1:0]  divider;
    logic [pwmw_pkg::BitsWidth-1:0] bits;
    logic                           last;
  } pwm_word_t;

  pwm_word_t words_due_q [$];
  pwm_word_t oldest;

  initial begin
    fail_count_o = 0;
    words_due_o  = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    fail_count_o = fail_count_o + 1;
  endtask

  function automatic void predict_words(input logic [pwmw_pkg::NsWidth-1:0] pulse);
    int unsigned ns, best_err, best_period, best_count, cnt, err, bits, left, n;
    int unsigned half;
    pwm_word_t w;
    ns = 32'(pulse);
    if (ns < ShortestNs) begin
      ns = ShortestNs;
    end else if (ns > LongestNs) begin
      ns = LongestNs;
    end
    best_err    = 32'hFFFF_FFFF;
    best_period = PeriodNs[0];
    best_count  = 0;
    for (int k = 0; k < NumPeriods; k++) begin
      cnt = ns / PeriodNs[k];
      if (cnt > MaxBits) begin
        cnt = MaxBits;
      end
      err = ns - cnt * PeriodNs[k];
      if (err < best_err) begin
        best_err    = err;
        best_period = PeriodNs[k];
        best_count  = cnt;
      end
    end
    bits = best_count;
    if (bits == 0) begin
      bits = 1;
    end else if (bits > MaxBits) begin
      bits = MaxBits;
    end
    half      = best_period / 2;
    w.divider = half[pwmw_pkg::DivWidth-1:0];
    w.bits    = bits[pwmw_pkg::BitsWidth-1:0];
    w.last    = 1'b0;
    left = bits;
    n    = 0;
    while (left >= BitsPerWord && n < MaxDataWords) begin
      w.word = '1;
      words_due_q.push_back(w);
      left = left - BitsPerWord;
      n++;
    end
    if (left > 0 && left < BitsPerWord && n < MaxDataWords) begin
      w.word = 32'hFFFF_FFFF << (BitsPerWord - left);
      words_due_q.push_back(w);
    end
    w.word = '0;
    w.last = 1'b1;
    words_due_q.push_back(w);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_due_q.delete();
    end else begin
      if (push_i && !full_o) begin
        predict_words(pulse_ns_i);
      end
      if (pop_i && !empty_o) begin
        if (words_due_q.size() == 0) begin
          report_mismatch("word with no request pending", '0, fifo_word_o);
        end else begin
          oldest = words_due_q.pop_front();
          if (fifo_word_o !== oldest.word) begin
            report_mismatch("fifo_word", oldest.word, fifo_word_o);
          end
          if (clock_divider_o !== oldest.divider) begin
            report_mismatch("clock_divider", 32'(oldest.divider), 32'(clock_divider_o));
          end
          if (pulse_bits_o !== oldest.bits) begin
            report_mismatch("pulse_bits", 32'(oldest.bits), 32'(pulse_bits_o));
          end
          if (last_o !== oldest.last) begin
            report_mismatch("last", 32'(oldest.last), 32'(last_o));
          end
        end
      end
    end
    words_due_o = words_due_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse width to PWM words testbench
// Sends directed and random pulse length requests with random gaps on both
// channels; the checker beside the core predicts and compares every word.
// ----------------------------------------------------------------------------
module tb;
  import pwmw_pkg::*;

  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned RandomRequests = 320;
  localparam int unsigned TailCycles     = 40;
  localparam int unsigned NumDirected    = 25;
  localparam int unsigned DirectedNs [NumDirected] = '{
    0, 1, 3, 4, 5, 7, 8, 9, 10, 20, 99, 124, 128, 129, 895, 896, 897,
    1000, 4000, 65535, 131072, 223999, 224000, 224001, 262143
  };

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 push_i     = 1'b0;
  logic                 pop_i      = 1'b0;
  logic [NsWidth-1:0]   pulse_ns_i = '0;
  logic                 full_o;
  logic                 empty_o;
  logic [WordBits-1:0]  fifo_word_o;
  logic [DivWidth-1:0]  clock_divider_o;
  logic [BitsWidth-1:0] pulse_bits_o;
  logic                 last_o;
  logic                 steady = 1'b0;
  int                   fail_count;
  int                   words_due;
  int unsigned          cycle_count = 0;

  pulse_width_to_pwm_words_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .pulse_ns_i      (pulse_ns_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .fifo_word_o     (fifo_word_o),
    .clock_divider_o (clock_divider_o),
    .pulse_bits_o    (pulse_bits_o),
    .last_o          (last_o)
  );

  pwm_words_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push_i),
    .full_o          (full_o),
    .pulse_ns_i      (pulse_ns_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .fifo_word_o     (fifo_word_o),
    .clock_divider_o (clock_divider_o),
    .pulse_bits_o    (pulse_bits_o),
    .last_o          (last_o),
    .fail_count_o    (fail_count),
    .words_due_o     (words_due)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [NsWidth-1:0] pick_pulse();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      return NsWidth'($urandom_range(0, (1 << NsWidth) - 1));
    end else if (sel < 6) begin
      return NsWidth'($urandom_range(0, 1200));
    end else if (sel < 8) begin
      return NsWidth'($urandom_range(PulseMinNs, PulseMaxNs));
    end
    return NsWidth'(BasePeriod[$urandom_range(0, NumBases - 1)] * $urandom_range(1, 224)
                    + $urandom_range(0, 3));
  endfunction

  task automatic send_request(input logic [NsWidth-1:0] pulse);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i     <= 1'b1;
    pulse_ns_i <= pulse;
    do @(posedge clk_i); while (full_o);
  endtask

  task automatic drain_words();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        pop_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      send_request(NsWidth'(DirectedNs[i]));
    end
    drain_words();
    for (int i = 0; i < RandomRequests; i++) begin
      if (i % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (i == RandomRequests / 2) begin
        drain_words();
      end
      send_request(pick_pulse());
    end
    drain_words();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
